// File: rtl/core/vtd_pkg.sv
// Shared constants, codes, types and helper functions for the vertex triple deduplicator.
// Used by vtd_ctrl, vtd_datapath and vertex_triple_deduplicator; depends on nothing.

package vtd_pkg;

  // Sizing of the vertex store and the attribute index space.
  localparam int MAX_VERTICES   = 4096;
  localparam int MAX_ATTRIBUTES = 65536;

  // Field widths of one item and one result.
  localparam int ATTR_W     = 17;
  localparam int OUT_VTX_W  = 12;
  localparam int STAT_W     = 3;
  localparam int KEY_W      = 3 * ATTR_W;

  // Vertex numbers, the vertex count (which must reach MAX_VERTICES) and the hash slots.
  // The slot table has twice as many entries as vertices, so a free slot always exists.
  localparam int VTX_W      = $clog2(MAX_VERTICES);
  localparam int CNT_W      = VTX_W + 1;
  localparam int SLOT_W     = VTX_W + 1;
  localparam int SLOT_DEPTH = 2 ** SLOT_W;

  // Configuration register indices.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXCOORD_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_COUNT   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_POSITION = 3'd1;
  localparam logic [STAT_W-1:0] STAT_TEXCOORD = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NORMAL   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_HALTED   = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // latch a new item, clear the mesh on start of mesh
    logic emit_halted;   // return the halted result at once
    logic rd_slot;       // read the hash slot under the probe pointer
    logic rd_vert;       // read key and owner slot of the vertex found there
    logic next_probe;    // step the probe pointer to the following slot
    logic emit_hit;      // return the stored vertex
    logic resolve_miss;  // range check, insert or report, and return the result
  } vtd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic halt_now;      // the mesh is halted and this item does not restart it
    logic live;          // the probed slot belongs to a vertex of the current mesh
    logic match;         // that vertex carries the key of the current item
  } vtd_stat_t;

  // Fold the packed triple onto the slot index by XOR of its bits.
  function automatic logic [SLOT_W-1:0] slot_hash(input logic [KEY_W-1:0] key);
    logic [SLOT_W-1:0] h;
    int                j;
    h = '0;
    j = 0;
    for (int i = 0; i < KEY_W; i++) begin
      h[j] = h[j] ^ key[i];
      j    = (j == SLOT_W - 1) ? 0 : j + 1;
    end
    return h;
  endfunction

  // True when the signed index is non-negative and below the clamped count.
  function automatic logic attr_in_range(input logic [ATTR_W-1:0] idx,
                                         input logic [ATTR_W-1:0] count);
    logic [31:0] lim;
    logic [31:0] val;
    lim = ({15'd0, count} > 32'(MAX_ATTRIBUTES)) ? 32'(MAX_ATTRIBUTES) : {15'd0, count};
    val = {16'd0, idx[ATTR_W-2:0]};
    return !idx[ATTR_W-1] && (val < lim);
  endfunction

endpackage

// File: rtl/core/vtd_ctrl.sv
// Controller state machine of the vertex triple deduplicator: sequences the hash probe.
// Depends on vtd_pkg for the command and status structs.

module vtd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  vtd_pkg::vtd_stat_t  stat,
  output vtd_pkg::vtd_cmd_t   cmd
);
  import vtd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SLOT = 2'd1;
  localparam logic [1:0] S_VERT = 2'd2;
  localparam logic [1:0] S_EVAL = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.halt_now) begin
            cmd.emit_halted = 1'b1;
          end else begin
            state_nxt = S_SLOT;
          end
        end
      end
      S_SLOT: begin
        cmd.rd_slot = 1'b1;
        state_nxt   = S_VERT;
      end
      S_VERT: begin
        cmd.rd_vert = 1'b1;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        if (stat.live && stat.match) begin
          cmd.emit_hit = 1'b1;
          state_nxt    = S_IDLE;
        end else if (stat.live) begin
          cmd.next_probe = 1'b1;
          state_nxt      = S_SLOT;
        end else begin
          cmd.resolve_miss = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: rtl/core/vtd_datapath.sv
// Datapath of the vertex triple deduplicator: configuration, hash slot table,
// vertex key store, vertex count, halt flag and result registers.
// Depends on vtd_pkg for constants, structs and the hash and range functions.

module vtd_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  vtd_pkg::vtd_cmd_t               cmd,
  output vtd_pkg::vtd_stat_t              stat,
  input  logic                            cfg_we,
  input  logic [vtd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vtd_pkg::ATTR_W-1:0]      cfg_wdata,
  input  logic                            in_start_mesh,
  input  logic signed [vtd_pkg::ATTR_W-1:0] in_position_index,
  input  logic signed [vtd_pkg::ATTR_W-1:0] in_texcoord_index,
  input  logic signed [vtd_pkg::ATTR_W-1:0] in_normal_index,
  output logic                            out_valid,
  output logic [vtd_pkg::OUT_VTX_W-1:0]   out_vertex_index,
  output logic                            out_is_new,
  output logic [vtd_pkg::STAT_W-1:0]      out_status
);
  import vtd_pkg::*;

  // Configuration registers.
  logic [ATTR_W-1:0] position_count_r;
  logic [ATTR_W-1:0] texcoord_count_r;
  logic [ATTR_W-1:0] normal_count_r;

  // Item under work and probe state.
  logic [KEY_W-1:0]  key_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  next_vertex_r;
  logic              halted_r;

  // Registered memory read data.
  logic [VTX_W-1:0]  slot_vtx_r;
  logic [KEY_W-1:0]  vtx_key_r;
  logic [SLOT_W-1:0] vtx_owner_r;

  // Result registers.
  logic                 out_valid_r;
  logic [OUT_VTX_W-1:0] out_vertex_index_r;
  logic                 out_is_new_r;
  logic [STAT_W-1:0]    out_status_r;

  // Memories: slot -> vertex, vertex -> key, vertex -> slot that points at it.
  logic [VTX_W-1:0]  slot_mem  [SLOT_DEPTH];
  logic [KEY_W-1:0]  key_mem   [MAX_VERTICES];
  logic [SLOT_W-1:0] owner_mem [MAX_VERTICES];

  logic              table_full;
  logic [STAT_W-1:0] miss_status;
  logic              do_insert;
  logic              set_halt;

  // Configuration writes; indices beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_count_r <= '0;
      texcoord_count_r <= '0;
      normal_count_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POSITION_COUNT: position_count_r <= cfg_wdata;
        REG_TEXCOORD_COUNT: texcoord_count_r <= cfg_wdata;
        REG_NORMAL_COUNT:   normal_count_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A slot is live only when it names a vertex of this mesh that points back at it,
  // so stale or unwritten slots never need clearing.
  assign stat.halt_now = halted_r && !in_start_mesh;
  assign stat.live     = ({1'b0, slot_vtx_r} < next_vertex_r) && (vtx_owner_r == slot_r);
  assign stat.match    = (vtx_key_r == key_r);

  // Outcome of a triple not found in the table: range checks first, then capacity.
  assign table_full = (next_vertex_r >= CNT_W'(MAX_VERTICES));

  always_comb begin
    if (!attr_in_range(key_r[ATTR_W-1:0], position_count_r)) begin
      miss_status = STAT_POSITION;
    end else if (!attr_in_range(key_r[2*ATTR_W-1:ATTR_W], texcoord_count_r)) begin
      miss_status = STAT_TEXCOORD;
    end else if (!attr_in_range(key_r[KEY_W-1:2*ATTR_W], normal_count_r)) begin
      miss_status = STAT_NORMAL;
    end else if (table_full) begin
      miss_status = STAT_FULL;
    end else begin
      miss_status = STAT_OK;
    end
  end

  assign do_insert = cmd.resolve_miss && (miss_status == STAT_OK);
  assign set_halt  = cmd.resolve_miss &&
                     ((miss_status == STAT_POSITION) || (miss_status == STAT_TEXCOORD) ||
                      (miss_status == STAT_NORMAL));

  // Item latch and probe pointer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= {in_normal_index, in_texcoord_index, in_position_index};
      slot_r <= slot_hash({in_normal_index, in_texcoord_index, in_position_index});
    end else if (cmd.next_probe) begin
      slot_r <= slot_r + 1'b1;
    end
  end

  // Vertex count and halt flag; a start of mesh clears both before the item is handled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_vertex_r <= '0;
      halted_r      <= 1'b0;
    end else begin
      if (cmd.load && in_start_mesh) begin
        next_vertex_r <= '0;
        halted_r      <= 1'b0;
      end
      if (do_insert) begin
        next_vertex_r <= next_vertex_r + 1'b1;
      end
      if (set_halt) begin
        halted_r <= 1'b1;
      end
    end
  end

  // Slot table.
  always_ff @(posedge clk) begin
    if (cmd.rd_slot) begin
      slot_vtx_r <= slot_mem[slot_r];
    end
    if (do_insert) begin
      slot_mem[slot_r] <= next_vertex_r[VTX_W-1:0];
    end
  end

  // Vertex key store.
  always_ff @(posedge clk) begin
    if (cmd.rd_vert) begin
      vtx_key_r <= key_mem[slot_vtx_r];
    end
    if (do_insert) begin
      key_mem[next_vertex_r[VTX_W-1:0]] <= key_r;
    end
  end

  // Owner slot of each vertex.
  always_ff @(posedge clk) begin
    if (cmd.rd_vert) begin
      vtx_owner_r <= owner_mem[slot_vtx_r];
    end
    if (do_insert) begin
      owner_mem[next_vertex_r[VTX_W-1:0]] <= slot_r;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_halted || cmd.emit_hit || cmd.resolve_miss;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.emit_halted) begin
      out_vertex_index_r <= '0;
      out_is_new_r       <= 1'b0;
      out_status_r       <= STAT_HALTED;
    end else if (cmd.emit_hit) begin
      out_vertex_index_r <= OUT_VTX_W'(slot_vtx_r);
      out_is_new_r       <= 1'b0;
      out_status_r       <= STAT_OK;
    end else if (cmd.resolve_miss) begin
      out_vertex_index_r <= do_insert ? OUT_VTX_W'(next_vertex_r[VTX_W-1:0]) : '0;
      out_is_new_r       <= do_insert;
      out_status_r       <= miss_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_vertex_index_r;
  assign out_is_new       = out_is_new_r;
  assign out_status       = out_status_r;

`ifndef SYNTH
  // The vertex count never runs past the capacity of the store.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_vertex_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  // A hit is only returned for a live slot whose key matches.
  a_hit_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_hit |-> (stat.live && stat.match))
    else $error("hit returned without a matching live slot");
`endif

endmodule

// File: rtl/core/vertex_triple_deduplicator.sv
// Top level of the vertex triple deduplicator: joins the controller and the datapath.
// Depends on vtd_pkg, vtd_ctrl and vtd_datapath.

// An item (one face corner) is taken when start is high and busy is low; its single
// result is registered and shown on the out_ ports for exactly one cycle under
// out_valid, and cannot be held off by the receiver. A halted mesh answers without a
// probe. Otherwise the item runs a linear probe through an 8192-slot hash table: each
// probe reads the slot memory, then the vertex key and owner memories, then compares,
// and the item steps on to the following slot while the slot is live but holds another
// key. A start of mesh takes effect at once, with no clearing pass: slot entries are
// trusted only when the vertex they name belongs to the current mesh and points back
// at them. Configuration writes are taken in any cycle and must only be made while the
// block is idle.

module vertex_triple_deduplicator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_start_mesh,
  input  logic signed [vtd_pkg::ATTR_W-1:0] in_position_index,
  input  logic signed [vtd_pkg::ATTR_W-1:0] in_texcoord_index,
  input  logic signed [vtd_pkg::ATTR_W-1:0] in_normal_index,
  output logic                              out_valid,
  output logic [vtd_pkg::OUT_VTX_W-1:0]     out_vertex_index,
  output logic                              out_is_new,
  output logic [vtd_pkg::STAT_W-1:0]        out_status,
  input  logic                              cfg_we,
  input  logic [vtd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vtd_pkg::ATTR_W-1:0]        cfg_wdata
);
  import vtd_pkg::*;

  vtd_cmd_t  cmd;
  vtd_stat_t stat;

  // Probe sequencer.
  vtd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Tables, counters and result registers.
  vtd_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_start_mesh     (in_start_mesh),
    .in_position_index (in_position_index),
    .in_texcoord_index (in_texcoord_index),
    .in_normal_index   (in_normal_index),
    .out_valid         (out_valid),
    .out_vertex_index  (out_vertex_index),
    .out_is_new        (out_is_new),
    .out_status        (out_status)
  );

`ifndef SYNTH
  // Every accepted item is either still at work or answered in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither busy nor answered");

  // A result is only shown once the item's work has finished.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // A failing status carries a zero vertex and no new flag.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> ((out_vertex_index == '0) && !out_is_new))
    else $error("failing result carries vertex data");
`endif

endmodule
